@@ hw/rtl/uqsp_pkg.sv @@
// Shared types, constants and decode helpers for the URL query string parser.
package uqsp_pkg;

    localparam int NAME_W  = 16;
    localparam int VALUE_W = 21;
    localparam int KIND_W  = 3;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int RES_MAX = 4;
    localparam int RES_AW  = $clog2(RES_MAX);

    localparam logic [NAME_W-1:0]  NAME_LIMIT_RST  = NAME_W'(1024);
    localparam logic [VALUE_W-1:0] VALUE_LIMIT_RST = VALUE_W'(1024 * 1024);

    localparam logic [KIND_W-1:0] KIND_NAME  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_VALUE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PAIR  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OK    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FAIL  = 3'd4;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_US    = 8'd31;
    localparam logic [7:0] CH_DEL   = 8'd127;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PCT  = 2'd1;
    localparam logic [1:0] PH_DIG  = 2'd2;

    // queue word from front to back: up to two decoded bytes plus end marks
    typedef struct packed {
        logic       b0_vld;
        logic [7:0] b0;
        logic       b1_vld;
        logic [7:0] b1;
        logic       fin;
        logic       empty_fail;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        dat;
    } t_res;

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // base-16 read of two chars: one blank or sign, digits, stop at non-digit
    function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] ha;
        logic [4:0] hb;
        logic [7:0] r;
        ha = hex_val(a);
        hb = hex_val(b);
        r  = 8'd0;
        if (is_blank(a) || a == CH_PLUS) begin
            if (hb[4]) r = {4'd0, hb[3:0]};
        end else if (a == CH_MINUS) begin
            if (hb[4]) r = 8'(8'd0 - {4'd0, hb[3:0]});
        end else if (ha[4]) begin
            r = hb[4] ? {ha[3:0], hb[3:0]} : {4'd0, ha[3:0]};
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/uqsp_front.sv @@
// Front end: accepts raw query bytes, percent-decodes and queues parser commands.
module uqsp_front
    import uqsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char,
    input  logic       i_last,
    input  logic       i_no_char,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_held,  n_held;
    logic       r_seen,  n_seen;
    logic       w_acc;
    t_cmd       w_cmd;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_seen  = r_seen;
        w_cmd   = '0;
        if (!i_no_char) begin
            n_seen = 1'b1;
            if (r_phase == PH_DIG) begin
                w_cmd.b0_vld = 1'b1;
                w_cmd.b0     = decode_pair(r_held, i_char);
                n_phase      = PH_IDLE;
                n_held       = 8'd0;
            end else if (r_phase == PH_PCT) begin
                if (i_last) begin
                    w_cmd.b0_vld = 1'b1;
                    w_cmd.b0     = CH_PCT;
                    w_cmd.b1_vld = 1'b1;
                    w_cmd.b1     = i_char;
                    n_phase      = PH_IDLE;
                end else begin
                    n_held  = i_char;
                    n_phase = PH_DIG;
                end
            end else if (i_char == CH_PCT && !i_last) begin
                n_phase = PH_PCT;
            end else begin
                w_cmd.b0_vld = 1'b1;
                w_cmd.b0     = i_char;
            end
        end
        if (i_last) begin
            w_cmd.fin = 1'b1;
            if (!n_seen) begin
                w_cmd.empty_fail = 1'b1;
            end else if (n_phase != PH_IDLE) begin
                // unfinished escape at the end passes through literally
                w_cmd.b0_vld = 1'b1;
                w_cmd.b0     = CH_PCT;
                if (n_phase == PH_DIG) begin
                    w_cmd.b1_vld = 1'b1;
                    w_cmd.b1     = n_held;
                end
            end
            n_phase = PH_IDLE;
            n_held  = 8'd0;
            n_seen  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
            r_seen  <= 1'b0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_seen  <= n_seen;
        end
    end

    assign o_push = w_acc && (w_cmd.b0_vld || w_cmd.fin);
    assign o_cmd  = w_cmd;

endmodule

@@ hw/rtl/uqsp_fifo.sv @@
// Short command queue between the decoder front end and the parser back end.
module uqsp_fifo
    import uqsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

@@ hw/rtl/uqsp_back.sv @@
// Back end: name/value parser and result serialiser.
module uqsp_back
    import uqsp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [NAME_W-1:0]  i_name_limit,
    input  logic [VALUE_W-1:0] i_value_limit,
    input  logic               i_empty,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [KIND_W-1:0]  o_kind,
    output logic [7:0]         o_dat,
    output logic               o_last
);

    typedef struct packed {
        logic               in_value;
        logic [NAME_W-1:0]  ncnt;
        logic [VALUE_W-1:0] vcnt;
        logic               failed;
    } t_pstate;

    typedef struct packed {
        t_pstate st;
        logic    vld;
        t_res    res;
    } t_pout;

    function automatic t_pout parse(input t_pstate st, input logic [7:0] c,
                                    input logic [NAME_W-1:0] nlim,
                                    input logic [VALUE_W-1:0] vlim);
        t_pout p;
        logic  ctrl;
        ctrl  = (c <= CH_US) || (c == CH_DEL);
        p     = '0;
        p.st  = st;
        if (!st.failed) begin
            if (!st.in_value) begin
                if (c == CH_EQ) begin
                    if (st.ncnt == '0) begin
                        p.st.failed = 1'b1;
                        p.vld       = 1'b1;
                        p.res.kind  = KIND_FAIL;
                    end else begin
                        p.st.in_value = 1'b1;
                    end
                end else if (c == CH_AMP) begin
                    if (st.ncnt != '0) begin
                        p.vld      = 1'b1;
                        p.res.kind = KIND_PAIR;
                        p.st.ncnt  = '0;
                    end
                end else if (c == CH_CR || c == CH_LF) begin
                    p.vld = 1'b0;
                end else if (ctrl || st.ncnt >= nlim) begin
                    p.st.failed = 1'b1;
                    p.vld       = 1'b1;
                    p.res.kind  = KIND_FAIL;
                end else begin
                    p.vld      = 1'b1;
                    p.res.kind = KIND_NAME;
                    p.res.dat  = c;
                    p.st.ncnt  = st.ncnt + 1'b1;
                end
            end else begin
                if (c == CH_AMP) begin
                    p.vld         = 1'b1;
                    p.res.kind    = KIND_PAIR;
                    p.st.ncnt     = '0;
                    p.st.vcnt     = '0;
                    p.st.in_value = 1'b0;
                end else if (c == CH_CR || c == CH_LF) begin
                    p.vld = 1'b0;
                end else if (ctrl || st.vcnt >= vlim) begin
                    p.st.failed = 1'b1;
                    p.vld       = 1'b1;
                    p.res.kind  = KIND_FAIL;
                end else begin
                    p.vld      = 1'b1;
                    p.res.kind = KIND_VALUE;
                    p.res.dat  = c;
                    p.st.vcnt  = st.vcnt + 1'b1;
                end
            end
        end
        return p;
    endfunction

    t_pstate           r_st, n_st;
    t_res              r_slot [RES_MAX];
    t_res              n_slot [RES_MAX];
    logic [RES_AW:0]   r_left, n_cnt;
    logic [RES_AW-1:0] r_idx;
    logic              w_load_ok;
    logic              w_out_acc;

    always_comb begin
        t_pout             p0;
        t_pout             p1;
        t_pstate           s1;
        t_pstate           s2;
        logic [RES_MAX-1:0] cv;
        t_res              cr [RES_MAX];
        p0 = '0;
        p1 = '0;
        s1 = r_st;
        if (i_cmd.b0_vld) begin
            p0 = parse(r_st, i_cmd.b0, i_name_limit, i_value_limit);
            s1 = p0.st;
        end
        s2 = s1;
        if (i_cmd.b1_vld) begin
            p1 = parse(s1, i_cmd.b1, i_name_limit, i_value_limit);
            s2 = p1.st;
        end
        cv    = '0;
        cr[0] = p0.res;
        cr[1] = p1.res;
        cr[2] = '{kind: KIND_PAIR, dat: 8'd0};
        cr[3] = '{kind: KIND_OK,   dat: 8'd0};
        cv[0] = p0.vld;
        cv[1] = p1.vld;
        n_st  = s2;
        if (i_cmd.fin) begin
            if (i_cmd.empty_fail) begin
                cv[3] = 1'b1;
                cr[3] = '{kind: KIND_FAIL, dat: 8'd0};
            end else if (!s2.failed) begin
                cv[2] = (s2.ncnt != '0);
                cv[3] = 1'b1;
            end
            n_st = '0;
        end
        // pack the produced results in order
        n_cnt = '0;
        for (int i = 0; i < RES_MAX; i++) begin
            n_slot[i] = '0;
        end
        for (int i = 0; i < RES_MAX; i++) begin
            if (cv[i]) begin
                n_slot[n_cnt[RES_AW-1:0]] = cr[i];
                n_cnt = n_cnt + 1'b1;
            end
        end
    end

    assign w_out_acc = o_valid && i_ready;
    assign w_load_ok = (r_left == '0) || ((r_left == (RES_AW+1)'(1)) && i_ready);
    assign o_pop     = !i_empty && w_load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= '0;
            r_left <= '0;
            r_idx  <= '0;
        end else begin
            if (o_pop) begin
                r_st   <= n_st;
                r_left <= n_cnt;
                r_idx  <= '0;
            end else if (w_out_acc) begin
                r_left <= r_left - 1'b1;
                r_idx  <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_slot <= n_slot;
        end
    end

    assign o_valid = (r_left != '0);
    assign o_kind  = r_slot[r_idx].kind;
    assign o_dat   = r_slot[r_idx].dat;
    assign o_last  = (r_left == (RES_AW+1)'(1));

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= (RES_AW+1)'(RES_MAX))
        else $error("result count out of range");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.fin) |=> (r_st == '0))
        else $error("query state not cleared at end");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (r_left == $past(r_left) && r_idx == $past(r_idx)))
        else $error("results advanced while stalled");

endmodule

@@ hw/rtl/url_query_string_parser_unit.sv @@
// Top level of the URL query string parser: config registers and front/queue/back.
// One raw query byte is taken per clock while the queue has room. Each word passes
// the percent decoder in the front end, and a word that yields a command lands in
// a four-entry command queue; the parser back end turns one queued command into up
// to four results (name byte, value byte, pair complete, query ok or failed) and
// sends them one per clock while m_axis_tready is high. A word that yields several
// results holds the back end until all are sent, which the queue absorbs until
// full, at which point s_axis_tready drops. Words that yield nothing (a lone '%',
// the first digit of an escape, bytes after a failure) leave no trace on the output.
// Registers: name_limit at byte address 0, value_limit at 4.
module url_query_string_parser_unit
    import uqsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,   // is_last
    input  logic        s_axis_tuser,   // [0] no_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // last_of_run
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [NAME_W-1:0]  r_name_limit;
    logic [VALUE_W-1:0] r_value_limit;
    logic               w_wr;
    logic               w_push;
    logic               w_full;
    logic               w_pop;
    logic               w_empty;
    t_cmd               w_cmd_in;
    t_cmd               w_cmd_out;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_limit  <= NAME_LIMIT_RST;
            r_value_limit <= VALUE_LIMIT_RST;
        end else if (w_wr) begin
            if (paddr[2]) r_value_limit <= pwdata[VALUE_W-1:0];
            else          r_name_limit  <= pwdata[NAME_W-1:0];
        end
    end

    assign prdata = paddr[2] ? {{(32-VALUE_W){1'b0}}, r_value_limit}
                             : {{(32-NAME_W){1'b0}}, r_name_limit};

    uqsp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_char    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .i_no_char (s_axis_tuser),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_cmd     (w_cmd_in)
    );

    uqsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_cmd_out)
    );

    uqsp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_name_limit  (r_name_limit),
        .i_value_limit (r_value_limit),
        .i_empty       (w_empty),
        .i_cmd         (w_cmd_out),
        .o_pop         (w_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_kind        (m_axis_tuser),
        .o_dat         (m_axis_tdata),
        .o_last        (m_axis_tlast)
    );

endmodule

@@ test/url_query_string_parser_unit_tb.sv @@
// Self-checking testbench for the URL query string parser: directed and random queries.
`timescale 1ns / 100ps

module url_query_string_parser_unit_tb;
    import uqsp_pkg::*;

    localparam logic [2:0] ADDR_NAME_LIMIT  = 3'd0;
    localparam logic [2:0] ADDR_VALUE_LIMIT = 3'd4;
    localparam int         SETTLE_CYCLES    = 16;

    typedef struct {
        logic [7:0] c;
        logic       lst;
        logic       none;
        logic       pause;
    } t_query_word;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] dat;
        logic       lst;
    } t_parse_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] char_in
    logic        s_axis_tlast = 1'b0;    // is_last
    logic        s_axis_tuser = 1'b0;    // [0] no_char
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [7:0]  m_axis_tdata;           // [7:0] out_byte
    wire         m_axis_tlast;           // last_of_run
    wire  [2:0]  m_axis_tuser;           // [2:0] kind
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    wire  [31:0] prdata;
    wire         pready;

    url_query_string_parser_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    t_query_word   pending_words[$];
    t_parse_result expected_results[$];
    t_parse_result step_results[$];

    // decoder/parser state mirrored by the predictor
    logic [1:0]         q_phase = PH_IDLE;
    logic [7:0]         q_held = 8'h00;
    logic               q_in_value = 1'b0;
    logic [NAME_W-1:0]  q_name_cnt = '0;
    logic [VALUE_W-1:0] q_value_cnt = '0;
    logic               q_failed = 1'b0;
    logic               q_seen = 1'b0;
    logic [NAME_W-1:0]  lim_name = NAME_LIMIT_RST;
    logic [VALUE_W-1:0] lim_value = VALUE_LIMIT_RST;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  drv_busy = 1'b0;
    int  n_errors = 0;
    int  n_words = 0;
    int  n_queries = 0;
    int  n_results = 0;
    int  n_settings = 1;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(6_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        n_errors++;
    endtask

    // ---------------- predictor ----------------

    function automatic logic [3:0] hex_nibble(input logic [7:0] c, output logic ok);
        ok = 1'b1;
        if (c >= "0" && c <= "9") return c[3:0];
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return c[3:0] + 4'd9;
        ok = 1'b0;
        return 4'h0;
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] a, input logic [7:0] b);
        logic       ok_a;
        logic       ok_b;
        logic [3:0] na;
        logic [3:0] nb;
        na = hex_nibble(a, ok_a);
        nb = hex_nibble(b, ok_b);
        if (a == CH_SP || (a >= CH_TAB && a <= CH_CR) || a == CH_PLUS)
            return ok_b ? {4'h0, nb} : 8'h00;
        if (a == CH_MINUS)
            return ok_b ? 8'h00 - {4'h0, nb} : 8'h00;
        if (!ok_a) return 8'h00;
        return ok_b ? {na, nb} : {4'h0, na};
    endfunction

    function automatic void add_result(input logic [2:0] kind, input logic [7:0] dat);
        t_parse_result r;
        if (step_results.size() < RES_MAX) begin
            r.kind = kind;
            r.dat  = dat;
            r.lst  = 1'b0;
            step_results.insert(step_results.size(), r);
        end
    endfunction

    function automatic void fail_query();
        q_failed = 1'b1;
        add_result(KIND_FAIL, 8'h00);
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        logic ctrl;
        ctrl = (c <= CH_US) || (c == CH_DEL);
        if (!q_failed) begin
            if (!q_in_value) begin
                if (c == CH_EQ) begin
                    if (q_name_cnt == 0) fail_query();
                    else q_in_value = 1'b1;
                end else if (c == CH_AMP) begin
                    if (q_name_cnt != 0) begin
                        add_result(KIND_PAIR, 8'h00);
                        q_name_cnt = '0;
                    end
                end else if (c == CH_CR || c == CH_LF) begin
                end else if (ctrl || q_name_cnt >= lim_name) begin
                    fail_query();
                end else begin
                    add_result(KIND_NAME, c);
                    q_name_cnt = q_name_cnt + 1'b1;
                end
            end else begin
                if (c == CH_AMP) begin
                    add_result(KIND_PAIR, 8'h00);
                    q_name_cnt  = '0;
                    q_value_cnt = '0;
                    q_in_value  = 1'b0;
                end else if (c == CH_CR || c == CH_LF) begin
                end else if (ctrl || q_value_cnt >= lim_value) begin
                    fail_query();
                end else begin
                    add_result(KIND_VALUE, c);
                    q_value_cnt = q_value_cnt + 1'b1;
                end
            end
        end
    endfunction

    function automatic void predict_word(input logic [7:0] c, input logic lst, input logic none);
        step_results.delete();
        if (!none) begin
            q_seen = 1'b1;
            if (q_phase == PH_DIG) begin
                parse_char(unescape(q_held, c));
                q_phase = PH_IDLE;
                q_held  = 8'h00;
            end else if (q_phase == PH_PCT) begin
                if (lst) begin
                    parse_char(CH_PCT);
                    parse_char(c);
                    q_phase = PH_IDLE;
                end else begin
                    q_held  = c;
                    q_phase = PH_DIG;
                end
            end else if (c == CH_PCT && !lst) begin
                q_phase = PH_PCT;
            end else begin
                parse_char(c);
            end
        end
        if (lst) begin
            if (!q_seen) begin
                fail_query();
            end else begin
                if (q_phase != PH_IDLE) begin
                    parse_char(CH_PCT);
                    if (q_phase == PH_DIG) parse_char(q_held);
                end
                if (!q_failed) begin
                    if (q_name_cnt != 0) add_result(KIND_PAIR, 8'h00);
                    add_result(KIND_OK, 8'h00);
                end
            end
            q_phase     = PH_IDLE;
            q_held      = 8'h00;
            q_in_value  = 1'b0;
            q_name_cnt  = '0;
            q_value_cnt = '0;
            q_failed    = 1'b0;
            q_seen      = 1'b0;
        end
        if (step_results.size() != 0) step_results[step_results.size() - 1].lst = 1'b1;
        foreach (step_results[k])
            expected_results.insert(expected_results.size(), step_results[k]);
    endfunction

    // ---------------- driver and monitor ----------------

    always @(posedge i_clk) begin : word_driver
        t_query_word w;
        if (!i_rst_n) begin
            drv_busy = 1'b0;
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_word(s_axis_tdata, s_axis_tlast, s_axis_tuser);
                n_words++;
                if (s_axis_tlast) n_queries++;
                drv_busy = 1'b0;
            end
            if (!drv_busy && pending_words.size() != 0) begin
                if (pending_words[0].pause) begin
                    if (expected_results.size() == 0) void'(pending_words.pop_front());
                end else if ($urandom_range(99) >= send_idle_pct) begin
                    w = pending_words.pop_front();
                    s_axis_tdata <= w.c;
                    s_axis_tlast <= w.lst;
                    s_axis_tuser <= w.none;
                    drv_busy = 1'b1;
                end
            end
            s_axis_tvalid <= drv_busy;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_parse_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    note_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                            m_axis_tuser, m_axis_tdata));
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.kind)
                        note_mismatch($sformatf("result %0d: kind %0d, expected %0d",
                                                n_results, m_axis_tuser, want.kind));
                    if (m_axis_tdata !== want.dat)
                        note_mismatch($sformatf("result %0d: byte %02h, expected %02h",
                                                n_results, m_axis_tdata, want.dat));
                    if (m_axis_tlast !== want.lst)
                        note_mismatch($sformatf("result %0d: last %0d, expected %0d",
                                                n_results, m_axis_tlast, want.lst));
                end
                n_results++;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------- stimulus ----------------

    function automatic void add_word(input logic [7:0] c, input logic lst, input logic none);
        t_query_word w;
        w.c     = c;
        w.lst   = lst;
        w.none  = none;
        w.pause = 1'b0;
        pending_words.insert(pending_words.size(), w);
    endfunction

    function automatic void add_text(input string s, input bit ends_query);
        for (int k = 0; k < s.len(); k++)
            add_word(s[k], ends_query && (k == s.len() - 1), 1'b0);
    endfunction

    function automatic logic [7:0] rand_digit();
        int r;
        int v;
        r = $urandom_range(99);
        v = $urandom_range(15);
        if (r < 60) begin
            if (v < 10) return 8'(8'h30 + v);
            return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + v - 10);
        end
        if (r < 70) return $urandom_range(1) ? CH_PLUS : CH_MINUS;
        if (r < 80) return $urandom_range(1) ? CH_SP : 8'($urandom_range(9, 13));
        return 8'($urandom_range(255));
    endfunction

    function automatic int gen_query();
        t_query_word body[$];
        t_query_word w;
        int          len;
        int          r;
        bit          noise;
        w.lst   = 1'b0;
        w.none  = 1'b0;
        w.pause = 1'b0;
        if ($urandom_range(29) == 0) begin
            add_word(8'($urandom_range(255)), 1'b1, 1'b1);
            return 1;
        end
        noise = ($urandom_range(9) == 0);
        len   = $urandom_range(1, 14);
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(99);
            w.none = 1'b0;
            if (noise) begin
                w.c = 8'($urandom_range(255));
            end else if (r < 40) begin
                w.c = 8'($urandom_range(32, 126));
            end else if (r < 50) begin
                w.c = CH_EQ;
            end else if (r < 60) begin
                w.c = CH_AMP;
            end else if (r < 78) begin
                w.c = CH_PCT;
                body.insert(body.size(), w);
                w.c = rand_digit();
                body.insert(body.size(), w);
                w.c = rand_digit();
            end else if (r < 83) begin
                w.c = $urandom_range(1) ? CH_CR : CH_LF;
            end else if (r < 86) begin
                w.c = $urandom_range(1) ? CH_DEL : 8'($urandom_range(31));
            end else if (r < 93) begin
                w.c = 8'($urandom_range(128, 255));
            end else if (r < 96) begin
                w.c    = 8'($urandom_range(255));
                w.none = 1'b1;
            end else begin
                w.c = CH_PCT;
            end
            body.insert(body.size(), w);
        end
        if ($urandom_range(1)) begin
            w.c    = 8'($urandom_range(255));
            w.none = 1'b1;
            body.insert(body.size(), w);
        end
        body[body.size() - 1].lst = 1'b1;
        foreach (body[k]) pending_words.insert(pending_words.size(), body[k]);
        return body.size();
    endfunction

    task automatic wait_drained();
        while (pending_words.size() != 0 || drv_busy || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input int nl, input int vl, input int send_pct, input int recv_pct,
                             input int n_target, input bit with_pause);
        int          added;
        t_query_word marker;
        wait_drained();
        apb_write(ADDR_NAME_LIMIT, 32'(nl));
        apb_write(ADDR_VALUE_LIMIT, 32'(vl));
        lim_name   = NAME_W'(nl);
        lim_value  = VALUE_W'(vl);
        n_settings++;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        added = 0;
        while (added < n_target / 2) added += gen_query();
        if (with_pause) begin
            marker.c     = 8'h00;
            marker.lst   = 1'b0;
            marker.none  = 1'b0;
            marker.pause = 1'b1;
            pending_words.insert(pending_words.size(), marker);
        end
        while (added < n_target) added += gen_query();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limits, no idling
        add_word(8'hFF, 1'b0, 1'b1);
        add_word(8'h00, 1'b1, 1'b1);
        add_text("%41=%-1\r&", 1'b0);
        add_word(8'h00, 1'b1, 1'b1);
        add_text("&=", 1'b0);
        add_word(CH_DEL, 1'b1, 1'b0);
        add_text("k% 9q", 1'b1);
        add_text("b==%", 1'b1);
        add_text("c%4", 1'b1);
        add_text("d%", 1'b0);
        add_word(8'h00, 1'b1, 1'b1);
        add_text("e%6", 1'b0);
        add_word(8'h00, 1'b1, 1'b1);

        run_phase(3, 2, 0, 0, 40, 1'b0);
        run_phase(0, 0, 64, 0, 10, 1'b0);
        run_phase(65535, 2097151, 64, 0, 40, 1'b0);
        run_phase(1, 1, 0, 64, 30, 1'b0);
        run_phase(6, 9, 8, 8, 40, 1'b1);
        wait_drained();

        $display("Summary: %0d words in %0d queries, %0d results checked, %0d limit settings",
                 n_words, n_queries, n_results, n_settings);
        $display("Covered escapes, signs, blanks, truncated percents, empty and failed queries");
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
